@@ rtl/swsr_pkg.sv @@
package swsr_pkg;

	// register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_WAIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_PHASE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES       = 3'd5;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TICK_W     = 16;
	localparam int unsigned BYTES_W    = 4;

	// reset values of the timing and byte-count registers, and the byte-count limit
	localparam logic [TICK_W-1:0]  START_LOW_RST   = 16'd10000;
	localparam logic [TICK_W-1:0]  START_HIGH_RST  = 16'd30;
	localparam logic [TICK_W-1:0]  RESP_WAIT_RST   = 16'd40;
	localparam logic [TICK_W-1:0]  RESP_PHASE_RST  = 16'd80;
	localparam logic [TICK_W-1:0]  BIT_SAMPLE_RST  = 16'd30;
	localparam logic [BYTES_W-1:0] BYTES_RST       = 4'd5;
	localparam logic [BYTES_W-1:0] BYTES_MAX       = 4'd8;

	// status codes
	localparam logic [1:0] STATUS_IDLE = 2'd0;
	localparam logic [1:0] STATUS_BUSY = 2'd1;
	localparam logic [1:0] STATUS_FAIL = 2'd2;

	// command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0]  start_low_ticks;
		logic [TICK_W-1:0]  start_high_ticks;
		logic [TICK_W-1:0]  response_wait_ticks;
		logic [TICK_W-1:0]  response_phase_ticks;
		logic [TICK_W-1:0]  bit_sample_ticks;
		logic [BYTES_W-1:0] bytes_to_read;
	} cfg_t;

	typedef struct packed {
		logic       drive_enable;
		logic       drive_level;
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [1:0] status;
	} result_t;

endpackage

@@ rtl/single_wire_sensor_reader_unit.sv @@
// Master side of a single-wire sensor read.
// Input channel (in_valid / in_stall): each beat is either a start command
// (cmd = 1) or a one-microsecond tick (cmd = 0) carrying the sampled
// line_level. Start drives the line low, then high, then releases it and
// checks the sensor response; data bits are then sampled and shifted in
// MSB first, and each finished byte is presented.
// Output channel (out_valid / out_stall): one result beat per input beat,
// carrying drive_enable/drive_level for the line, byte_valid, data_byte,
// last_byte and status (idle/done, busy, no response).
// Each result beat is registered and shows in the cycle after its input beat; one
// beat per cycle is sustained while the output is not stalled, the sequencer state and
// the result register being updated in the same cycle. A held result stalls the input
// only while the receiver stalls the output.
// Configuration (cfg_write / cfg_index / cfg_data) writes one timing or
// byte-count register per cycle; write only while the block is idle.
// Reset returns the sequencer to idle, drops any pending result and loads
// the default timings.
module single_wire_sensor_reader_unit
	import swsr_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic                  line_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  drive_enable,
	output logic                  drive_level,
	output logic                  byte_valid,
	output logic [7:0]            data_byte,
	output logic                  last_byte,
	output logic [1:0]            status
);

	cfg_t    cfg;
	result_t result;

	swsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swsr_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign drive_enable = result.drive_enable;
	assign drive_level  = result.drive_level;
	assign byte_valid   = result.byte_valid;
	assign data_byte    = result.data_byte;
	assign last_byte    = result.last_byte;
	assign status       = result.status;

	// a start beat always shows the line driven low next cycle
	a_start_drives_low: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_START |=>
		out_valid && drive_enable && !drive_level && status == STATUS_BUSY)
		else $error("start beat did not drive the line low");

	// the line is only driven while busy
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_enable |-> status == STATUS_BUSY)
		else $error("line driven outside a busy phase");

	// byte fields stay clear without a byte
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> data_byte == 8'd0 && !last_byte)
		else $error("byte fields set without byte_valid");

	// a held result blocks the input side
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted over a stalled result");

endmodule

@@ rtl/swsr_cfg.sv @@
module swsr_cfg
	import swsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// write one register per beat; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks      <= START_LOW_RST;
			cfg_q.start_high_ticks     <= START_HIGH_RST;
			cfg_q.response_wait_ticks  <= RESP_WAIT_RST;
			cfg_q.response_phase_ticks <= RESP_PHASE_RST;
			cfg_q.bit_sample_ticks     <= BIT_SAMPLE_RST;
			cfg_q.bytes_to_read        <= BYTES_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_LOW:  cfg_q.start_low_ticks      <= cfg_data;
				REG_START_HIGH: cfg_q.start_high_ticks     <= cfg_data;
				REG_RESP_WAIT:  cfg_q.response_wait_ticks  <= cfg_data;
				REG_RESP_PHASE: cfg_q.response_phase_ticks <= cfg_data;
				REG_BIT_SAMPLE: cfg_q.bit_sample_ticks     <= cfg_data;
				REG_BYTES:      cfg_q.bytes_to_read        <= cfg_data[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/swsr_seq.sv @@
module swsr_seq
	import swsr_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    cmd,
	input  logic    line_level,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_LOW,
		PH_START_HIGH,
		PH_RESP_LOW,
		PH_RESP_HIGH,
		PH_RESP_TAIL,
		PH_BIT_RISE,
		PH_BIT_SAMPLE,
		PH_BIT_FALL,
		PH_FAIL
	} phase_t;

	localparam int unsigned CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [2:0]             bit_idx_q, bit_idx_d;
	logic [7:0]             shift_q, shift_d;
	logic [BYTES_W-1:0]     byte_idx_q, byte_idx_d;
	logic                   out_valid_q;
	result_t                result_q, result_d;

	logic                   accept;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [TICK_W-1:0]      limit;
	logic                   wait_end;
	logic [BYTES_W-1:0]     byte_target;
	logic [BYTES_W-1:0]     byte_idx_inc;
	logic [7:0]             shift_new;

	// hold input while a result waits on a stalled receiver
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// saturating wait counter and its limit for the current phase
	always_comb begin
		cnt_inc = (tick_q != CNT_MAX) ? tick_q + 1'b1 : tick_q;
		unique case (phase_q)
			PH_START_LOW:  limit = cfg.start_low_ticks;
			PH_START_HIGH: limit = cfg.start_high_ticks;
			PH_RESP_LOW:   limit = cfg.response_wait_ticks;
			PH_RESP_HIGH,
			PH_RESP_TAIL:  limit = cfg.response_phase_ticks;
			default:       limit = cfg.bit_sample_ticks;
		endcase
		wait_end = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == CNT_MAX);
	end

	// clamp the byte count to one through eight
	always_comb begin
		if (cfg.bytes_to_read == '0)
			byte_target = BYTES_W'(1);
		else if (cfg.bytes_to_read > BYTES_MAX)
			byte_target = BYTES_MAX;
		else
			byte_target = cfg.bytes_to_read;
	end

	assign byte_idx_inc = byte_idx_q + 1'b1;
	assign shift_new    = {shift_q[6:0], line_level};

	// next state and result for one beat
	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bit_idx_d  = bit_idx_q;
		shift_d    = shift_q;
		byte_idx_d = byte_idx_q;
		result_d   = '0;

		if (cmd == CMD_START) begin
			phase_d    = PH_START_LOW;
			tick_d     = '0;
			bit_idx_d  = '0;
			shift_d    = '0;
			byte_idx_d = '0;
		end else begin
			unique case (phase_q)
				PH_START_LOW, PH_START_HIGH, PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_TAIL: begin
					tick_d = wait_end ? '0 : cnt_inc;
					if (wait_end) begin
						unique case (phase_q)
							PH_START_LOW:  phase_d = PH_START_HIGH;
							PH_START_HIGH: phase_d = PH_RESP_LOW;
							PH_RESP_LOW:   phase_d = line_level ? PH_FAIL : PH_RESP_HIGH;
							PH_RESP_HIGH:  phase_d = line_level ? PH_RESP_TAIL : PH_FAIL;
							default:       phase_d = PH_BIT_RISE;
						endcase
					end
				end
				PH_BIT_RISE: begin
					if (line_level) begin
						tick_d  = '0;
						phase_d = PH_BIT_SAMPLE;
					end
				end
				PH_BIT_SAMPLE: begin
					tick_d = wait_end ? '0 : cnt_inc;
					if (wait_end) begin
						if (bit_idx_q == 3'd7) begin
							result_d.byte_valid = 1'b1;
							result_d.data_byte  = shift_new;
							result_d.last_byte  = (byte_idx_inc >= byte_target);
							byte_idx_d          = byte_idx_inc;
							shift_d             = '0;
							bit_idx_d           = '0;
						end else begin
							shift_d   = shift_new;
							bit_idx_d = bit_idx_q + 1'b1;
						end
						if (line_level)
							phase_d = PH_BIT_FALL;
						else if (bit_idx_q == 3'd7 && byte_idx_inc >= byte_target)
							phase_d = PH_IDLE;
						else
							phase_d = PH_BIT_RISE;
					end
				end
				PH_BIT_FALL: begin
					if (!line_level)
						phase_d = (byte_idx_q >= byte_target) ? PH_IDLE : PH_BIT_RISE;
				end
				default: ;
			endcase
		end

		// line drive and status follow the new phase
		unique case (phase_d)
			PH_START_LOW: begin
				result_d.drive_enable = 1'b1;
				result_d.drive_level  = 1'b0;
				result_d.status       = STATUS_BUSY;
			end
			PH_START_HIGH: begin
				result_d.drive_enable = 1'b1;
				result_d.drive_level  = 1'b1;
				result_d.status       = STATUS_BUSY;
			end
			PH_IDLE: result_d.status = STATUS_IDLE;
			PH_FAIL: result_d.status = STATUS_FAIL;
			default: result_d.status = STATUS_BUSY;
		endcase
	end

	// advance state on each accepted beat; hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_idx_q   <= '0;
			shift_q     <= '0;
			byte_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				tick_q      <= tick_d;
				bit_idx_q   <= bit_idx_d;
				shift_q     <= shift_d;
				byte_idx_q  <= byte_idx_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept)
			result_q <= result_d;
	end

endmodule
